// ===== hw/rtl/gpt_pkg.sv =====
// Package for the gimbal pan/tilt PID block: widths, constants, register
// indexes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package gpt_pkg;

    localparam int FRAME_WIDTH  = 1920;
    localparam int FRAME_HEIGHT = 1080;
    localparam int FRAME_MAX    = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
    localparam int DIV_W        = $clog2(FRAME_MAX) + 1;

    localparam int COORD_W    = 16;
    localparam int CONF_W     = 8;
    localparam int GAIN_W     = 16;
    localparam int CH_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = $clog2(NUM_REGS);

    localparam int DIFF_W     = COORD_W + 1;
    localparam int ZOOM_SHIFT = 8;
    localparam int MAGP_W     = DIFF_W + GAIN_W;
    localparam int MAG_W      = MAGP_W + ZOOM_SHIFT;

    localparam int RATE_W      = 20;
    localparam int DRATE_W     = RATE_W + 1;
    localparam int INTEG_W     = 32;
    localparam int MA_W        = INTEG_W;
    localparam int MB_W        = GAIN_W + 1;
    localparam int PROD_W      = MA_W + MB_W;
    localparam int I_SHIFT     = 8;
    localparam int DECAY_SHIFT = 16;
    localparam int CMD_SHIFT   = 24;
    localparam int CMD_W       = 42;
    localparam int CMDQ_W      = CMD_W - CMD_SHIFT;
    localparam int CMDI_W      = 8;

    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = RATE_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int DECAY_Q16  = 62915;
    localparam int CMD_LIMIT  = 100;
    localparam int DEAD_BAND  = 3;
    localparam int CENTRE     = 1023;
    localparam int PAN_SCALE  = 10;
    localparam int TILT_SCALE = 4;

    localparam int RST_PAN_P   = 20480;
    localparam int RST_PAN_I   = 0;
    localparam int RST_PAN_D   = 0;
    localparam int RST_TILT_P  = 15360;
    localparam int RST_TILT_I  = 0;
    localparam int RST_TILT_D  = 0;
    localparam int RST_ZOOM    = 256;
    localparam int RST_CONF_TH = 50;

    localparam logic AXIS_PAN  = 1'b0;
    localparam logic AXIS_TILT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAN_P,
        REG_PAN_I,
        REG_PAN_D,
        REG_TILT_P,
        REG_TILT_I,
        REG_TILT_D,
        REG_ZOOM,
        REG_CONF_TH
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MS_DZ,
        MS_I,
        MS_P,
        MS_D,
        MS_K
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GATE,
        ST_DZ,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RATE,
        ST_MUL_I,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_K,
        ST_FIN,
        ST_CHAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     axis;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        logic     rate_en;
        logic     acc_en;
        logic     cmd_init;
        logic     cmd_add;
        logic     fin_en;
        logic     chan_en;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic gate_ok;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/gpt_div.sv =====
// Iterative restoring divider, two quotient bits per cycle, with an
// overflow flag for quotients past the rate width. Uses gpt_pkg.
`timescale 1ns / 1ps

module gpt_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gpt_pkg::MAG_W-1:0]   dividend,
    input  logic [gpt_pkg::DIV_W-1:0]   divisor,
    output logic                        done,
    output logic [gpt_pkg::RATE_W-1:0]  quot,
    output logic                        ovf
);

    localparam int HI_W = gpt_pkg::MAG_W - gpt_pkg::RATE_W;

    logic                           busy_reg;
    logic [gpt_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [gpt_pkg::DIV_W-1:0]      rem_reg;
    logic [gpt_pkg::DIV_W-1:0]      rem_next;
    logic [gpt_pkg::RATE_W-1:0]     lo_reg;
    logic [gpt_pkg::RATE_W-1:0]     lo_next;
    logic [gpt_pkg::RATE_W-1:0]     quot_reg;
    logic [gpt_pkg::RATE_W-1:0]     quot_next;
    logic [gpt_pkg::DIV_W-1:0]      dsr_reg;
    logic                           ovf_reg;
    logic [HI_W-1:0]                hi;
    logic [gpt_pkg::DIV_W-1:0]      trial;

    assign hi = dividend[gpt_pkg::MAG_W-1:gpt_pkg::RATE_W];

    always_comb begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quot_next = quot_reg;
        trial     = '0;
        for (int k = 0; k < gpt_pkg::DIV_BITS; k++) begin
            trial   = {rem_next[gpt_pkg::DIV_W-2:0], lo_next[gpt_pkg::RATE_W-1]};
            lo_next = {lo_next[gpt_pkg::RATE_W-2:0], 1'b0};
            if (trial >= dsr_reg) begin
                rem_next  = trial - dsr_reg;
                quot_next = {quot_next[gpt_pkg::RATE_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_next[gpt_pkg::RATE_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= gpt_pkg::DIV_CNT_W'(gpt_pkg::DIV_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - gpt_pkg::DIV_CNT_W'(1);
            if (cnt_reg == gpt_pkg::DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, hi[gpt_pkg::DIV_W-2:0]};
            lo_reg   <= dividend[gpt_pkg::RATE_W-1:0];
            quot_reg <= '0;
            dsr_reg  <= divisor;
            ovf_reg  <= (hi >= {{(HI_W-gpt_pkg::DIV_W){1'b0}}, divisor});
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            lo_reg   <= lo_next;
            quot_reg <= quot_next;
        end
    end

    assign done = !busy_reg;
    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

// ===== hw/rtl/gpt_datapath.sv =====
// Datapath: config registers, axis state, shared multiplier, divider,
// PID accumulation, channel update and output register. Uses gpt_pkg, gpt_div.
`timescale 1ns / 1ps

module gpt_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  gpt_pkg::cmd_t                   cmd,
    output gpt_pkg::sts_t                   sts,
    input  logic [gpt_pkg::COORD_W-1:0]     s_target_col,
    input  logic [gpt_pkg::COORD_W-1:0]     s_target_row,
    input  logic [gpt_pkg::CONF_W-1:0]      s_track_confidence,
    input  logic                            cfg_wr_en,
    input  logic [gpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gpt_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gpt_pkg::CH_W-1:0]        m_pan_channel,
    output logic [gpt_pkg::CH_W-1:0]        m_tilt_channel,
    output logic                            m_control_applied
);

    localparam logic signed [gpt_pkg::CMDQ_W-1:0] Q_LIM  = gpt_pkg::CMDQ_W'(gpt_pkg::CMD_LIMIT);
    localparam logic signed [gpt_pkg::CMDQ_W-1:0] Q_NLIM = -Q_LIM;
    localparam logic signed [gpt_pkg::CMDI_W-1:0] I_LIM  = gpt_pkg::CMDI_W'(gpt_pkg::CMD_LIMIT);
    localparam logic signed [gpt_pkg::CMDI_W-1:0] DB_HI  = gpt_pkg::CMDI_W'(gpt_pkg::DEAD_BAND);
    localparam logic signed [gpt_pkg::CMDI_W-1:0] DB_LO  = -DB_HI;
    localparam logic [gpt_pkg::RATE_W-1:0] RATE_MAX_V = {1'b0, {(gpt_pkg::RATE_W-1){1'b1}}};
    localparam logic [gpt_pkg::RATE_W-1:0] RATE_MIN_V = {1'b1, {(gpt_pkg::RATE_W-1){1'b0}}};
    localparam int ACC_W = gpt_pkg::INTEG_W + 2;

    // configuration
    logic [gpt_pkg::GAIN_W-1:0] pan_p_reg, pan_i_reg, pan_d_reg;
    logic [gpt_pkg::GAIN_W-1:0] tilt_p_reg, tilt_i_reg, tilt_d_reg;
    logic [gpt_pkg::GAIN_W-1:0] zoom_reg;
    logic [gpt_pkg::CONF_W-1:0] conf_th_reg;

    // per-axis state
    logic [gpt_pkg::INTEG_W-1:0] integ_reg [2];
    logic [gpt_pkg::RATE_W-1:0]  last_reg  [2];
    logic [gpt_pkg::CH_W-1:0]    ch_reg    [2];

    // transaction and working registers
    logic [gpt_pkg::COORD_W-1:0] col_reg, row_reg;
    logic                        gate_reg;
    logic signed [gpt_pkg::PROD_W-1:0] prod_reg;
    logic                        neg_reg;
    logic [gpt_pkg::RATE_W-1:0]  rate_reg;
    logic [gpt_pkg::INTEG_W-1:0] acc_reg;
    logic [gpt_pkg::CMD_W-1:0]   cmd_reg;
    logic signed [gpt_pkg::CMDI_W-1:0] cmdi_reg;
    logic                        m_valid_reg;
    logic [gpt_pkg::CH_W-1:0]    m_pan_reg, m_tilt_reg;
    logic                        m_applied_reg;

    // combinational
    logic                        gate_next;
    logic [gpt_pkg::COORD_W-1:0] coord;
    logic [gpt_pkg::DIFF_W-1:0]  half;
    logic [gpt_pkg::DIFF_W-1:0]  diff;
    logic [gpt_pkg::DIV_W-1:0]   frame_sz;
    logic [gpt_pkg::GAIN_W-1:0]  gain_p, gain_i, gain_d;
    logic [gpt_pkg::DRATE_W-1:0] drate;
    logic [gpt_pkg::MA_W-1:0]    mul_a;
    logic [gpt_pkg::MB_W-1:0]    mul_b;
    logic signed [gpt_pkg::PROD_W-1:0] mul_p;
    logic                        prod_neg;
    logic [gpt_pkg::PROD_W-1:0]  prod_abs;
    logic [gpt_pkg::MAG_W-1:0]   div_mag;
    logic                        div_done;
    logic [gpt_pkg::RATE_W-1:0]  div_quot;
    logic                        div_ovf;
    logic [gpt_pkg::RATE_W-1:0]  rate_next;
    logic [gpt_pkg::PROD_W-1:0]  bias_i, bias_k;
    logic [ACC_W-1:0]            acc_sum;
    logic [gpt_pkg::INTEG_W-1:0] acc_next;
    logic [gpt_pkg::INTEG_W-1:0] integ_next;
    logic [gpt_pkg::CMD_W-1:0]   cmd_bias;
    logic signed [gpt_pkg::CMDQ_W-1:0] cmd_q;
    logic signed [gpt_pkg::CMDI_W-1:0] cmdi_next;
    logic [gpt_pkg::CH_W-1:0]    cmdi_ext, scale, ch_step, ch_next;

    assign gate_next = (s_track_confidence > conf_th_reg)
                    && (s_target_col != {gpt_pkg::COORD_W{1'b1}})
                    && (s_target_row != {gpt_pkg::COORD_W{1'b1}});

    // axis selection
    always_comb begin
        if (cmd.axis == gpt_pkg::AXIS_TILT) begin
            coord    = row_reg;
            half     = gpt_pkg::DIFF_W'(gpt_pkg::FRAME_HEIGHT / 2);
            frame_sz = gpt_pkg::DIV_W'(gpt_pkg::FRAME_HEIGHT);
            gain_p   = tilt_p_reg;
            gain_i   = tilt_i_reg;
            gain_d   = tilt_d_reg;
            scale    = gpt_pkg::CH_W'(gpt_pkg::TILT_SCALE);
        end else begin
            coord    = col_reg;
            half     = gpt_pkg::DIFF_W'(gpt_pkg::FRAME_WIDTH / 2);
            frame_sz = gpt_pkg::DIV_W'(gpt_pkg::FRAME_WIDTH);
            gain_p   = pan_p_reg;
            gain_i   = pan_i_reg;
            gain_d   = pan_d_reg;
            scale    = gpt_pkg::CH_W'(gpt_pkg::PAN_SCALE);
        end
    end

    assign diff  = {coord[gpt_pkg::COORD_W-1], coord} - half;
    assign drate = {rate_reg[gpt_pkg::RATE_W-1], rate_reg}
                 - {last_reg[cmd.axis][gpt_pkg::RATE_W-1], last_reg[cmd.axis]};

    // shared multiplier operands
    always_comb begin
        case (cmd.mul_sel)
            gpt_pkg::MS_DZ: begin
                mul_a = {{(gpt_pkg::MA_W-gpt_pkg::DIFF_W){diff[gpt_pkg::DIFF_W-1]}}, diff};
                mul_b = {1'b0, zoom_reg};
            end
            gpt_pkg::MS_I: begin
                mul_a = {{(gpt_pkg::MA_W-gpt_pkg::RATE_W){rate_reg[gpt_pkg::RATE_W-1]}},
                         rate_reg};
                mul_b = {1'b0, gain_i};
            end
            gpt_pkg::MS_P: begin
                mul_a = {{(gpt_pkg::MA_W-gpt_pkg::RATE_W){rate_reg[gpt_pkg::RATE_W-1]}},
                         rate_reg};
                mul_b = {1'b0, gain_p};
            end
            gpt_pkg::MS_D: begin
                mul_a = {{(gpt_pkg::MA_W-gpt_pkg::DRATE_W){drate[gpt_pkg::DRATE_W-1]}}, drate};
                mul_b = {1'b0, gain_d};
            end
            gpt_pkg::MS_K: begin
                mul_a = acc_reg;
                mul_b = gpt_pkg::MB_W'(gpt_pkg::DECAY_Q16);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = $signed(mul_a) * $signed(mul_b);

    // divider feed: |diff * zoom| * 256
    assign prod_neg = prod_reg[gpt_pkg::PROD_W-1];
    assign prod_abs = prod_neg ? (~prod_reg + gpt_pkg::PROD_W'(1)) : prod_reg;
    assign div_mag  = {prod_abs[gpt_pkg::MAGP_W-1:0], {gpt_pkg::ZOOM_SHIFT{1'b0}}};

    gpt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_mag),
        .divisor  (frame_sz),
        .done     (div_done),
        .quot     (div_quot),
        .ovf      (div_ovf)
    );

    always_comb begin
        if (neg_reg) begin
            if (div_ovf || (div_quot > RATE_MIN_V)) begin
                rate_next = RATE_MIN_V;
            end else begin
                rate_next = ~div_quot + gpt_pkg::RATE_W'(1);
            end
        end else begin
            if (div_ovf || div_quot[gpt_pkg::RATE_W-1]) begin
                rate_next = RATE_MAX_V;
            end else begin
                rate_next = div_quot;
            end
        end
    end

    // integral: saturating add of trunc0(I*rate / 2^8)
    assign bias_i  = prod_reg + {{(gpt_pkg::PROD_W-gpt_pkg::I_SHIFT){1'b0}},
                                 {gpt_pkg::I_SHIFT{prod_neg}}};
    assign acc_sum = {{2{integ_reg[cmd.axis][gpt_pkg::INTEG_W-1]}}, integ_reg[cmd.axis]}
                   + bias_i[ACC_W+gpt_pkg::I_SHIFT-1:gpt_pkg::I_SHIFT];

    always_comb begin
        if (acc_sum[ACC_W-1:gpt_pkg::INTEG_W-1] == '0
                || acc_sum[ACC_W-1:gpt_pkg::INTEG_W-1] == '1) begin
            acc_next = acc_sum[gpt_pkg::INTEG_W-1:0];
        end else if (acc_sum[ACC_W-1]) begin
            acc_next = {1'b1, {(gpt_pkg::INTEG_W-1){1'b0}}};
        end else begin
            acc_next = {1'b0, {(gpt_pkg::INTEG_W-1){1'b1}}};
        end
    end

    // leak: trunc0(acc * 0.96)
    assign bias_k     = prod_reg + {{(gpt_pkg::PROD_W-gpt_pkg::DECAY_SHIFT){1'b0}},
                                    {gpt_pkg::DECAY_SHIFT{prod_neg}}};
    assign integ_next = bias_k[gpt_pkg::INTEG_W+gpt_pkg::DECAY_SHIFT-1:gpt_pkg::DECAY_SHIFT];

    // command: trunc0(cmd / 2^24), clamped
    assign cmd_bias = cmd_reg + {{(gpt_pkg::CMD_W-gpt_pkg::CMD_SHIFT){1'b0}},
                                 {gpt_pkg::CMD_SHIFT{cmd_reg[gpt_pkg::CMD_W-1]}}};
    assign cmd_q    = cmd_bias[gpt_pkg::CMD_W-1:gpt_pkg::CMD_SHIFT];

    always_comb begin
        if (cmd_q > Q_LIM) begin
            cmdi_next = I_LIM;
        end else if (cmd_q < Q_NLIM) begin
            cmdi_next = -I_LIM;
        end else begin
            cmdi_next = cmd_q[gpt_pkg::CMDI_W-1:0];
        end
    end

    assign cmdi_ext = {{(gpt_pkg::CH_W-gpt_pkg::CMDI_W){cmdi_reg[gpt_pkg::CMDI_W-1]}}, cmdi_reg};
    assign ch_step  = cmdi_ext * scale;
    assign ch_next  = ((cmdi_reg > DB_LO) && (cmdi_reg < DB_HI))
                    ? gpt_pkg::CH_W'(gpt_pkg::CENTRE)
                    : ch_reg[cmd.axis] + ch_step;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_p_reg   <= gpt_pkg::GAIN_W'(gpt_pkg::RST_PAN_P);
            pan_i_reg   <= gpt_pkg::GAIN_W'(gpt_pkg::RST_PAN_I);
            pan_d_reg   <= gpt_pkg::GAIN_W'(gpt_pkg::RST_PAN_D);
            tilt_p_reg  <= gpt_pkg::GAIN_W'(gpt_pkg::RST_TILT_P);
            tilt_i_reg  <= gpt_pkg::GAIN_W'(gpt_pkg::RST_TILT_I);
            tilt_d_reg  <= gpt_pkg::GAIN_W'(gpt_pkg::RST_TILT_D);
            zoom_reg    <= gpt_pkg::GAIN_W'(gpt_pkg::RST_ZOOM);
            conf_th_reg <= gpt_pkg::CONF_W'(gpt_pkg::RST_CONF_TH);
        end else if (cfg_wr_en) begin
            case (gpt_pkg::cfg_reg_t'(cfg_index))
                gpt_pkg::REG_PAN_P:   pan_p_reg   <= cfg_wr_data;
                gpt_pkg::REG_PAN_I:   pan_i_reg   <= cfg_wr_data;
                gpt_pkg::REG_PAN_D:   pan_d_reg   <= cfg_wr_data;
                gpt_pkg::REG_TILT_P:  tilt_p_reg  <= cfg_wr_data;
                gpt_pkg::REG_TILT_I:  tilt_i_reg  <= cfg_wr_data;
                gpt_pkg::REG_TILT_D:  tilt_d_reg  <= cfg_wr_data;
                gpt_pkg::REG_ZOOM:    zoom_reg    <= cfg_wr_data;
                gpt_pkg::REG_CONF_TH: conf_th_reg <= cfg_wr_data[gpt_pkg::CONF_W-1:0];
                default: ;
            endcase
        end
    end

    // axis state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 2; a++) begin
                integ_reg[a] <= '0;
                last_reg[a]  <= '0;
                ch_reg[a]    <= gpt_pkg::CH_W'(gpt_pkg::CENTRE);
            end
        end else begin
            if (cmd.fin_en) begin
                integ_reg[cmd.axis] <= integ_next;
                last_reg[cmd.axis]  <= rate_reg;
            end
            if (cmd.chan_en) begin
                ch_reg[cmd.axis] <= ch_next;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            col_reg  <= s_target_col;
            row_reg  <= s_target_row;
            gate_reg <= gate_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.div_start) begin
            neg_reg <= prod_neg;
        end
        if (cmd.rate_en) begin
            rate_reg <= rate_next;
        end
        if (cmd.acc_en) begin
            acc_reg <= acc_next;
        end
        if (cmd.cmd_init) begin
            cmd_reg <= prod_reg[gpt_pkg::CMD_W-1:0]
                     + {{(gpt_pkg::CMD_W-gpt_pkg::INTEG_W-8){acc_reg[gpt_pkg::INTEG_W-1]}},
                        acc_reg, 8'b0};
        end else if (cmd.cmd_add) begin
            cmd_reg <= cmd_reg + prod_reg[gpt_pkg::CMD_W-1:0];
        end
        if (cmd.fin_en) begin
            cmdi_reg <= cmdi_next;
        end
        if (cmd.out_load) begin
            m_pan_reg     <= ch_reg[gpt_pkg::AXIS_PAN];
            m_tilt_reg    <= ch_reg[gpt_pkg::AXIS_TILT];
            m_applied_reg <= gate_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.gate_ok  = gate_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_pan_channel     = m_pan_reg;
    assign m_tilt_channel    = m_tilt_reg;
    assign m_control_applied = m_applied_reg;

endmodule

// ===== hw/rtl/gpt_ctrl.sv =====
// Controller state machine: sequences the gate check, both PID axes and
// the output load. Uses gpt_pkg.
`timescale 1ns / 1ps

module gpt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  gpt_pkg::sts_t  sts,
    output gpt_pkg::cmd_t  cmd
);

    gpt_pkg::state_t state_reg, state_next;
    logic            axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gpt_pkg::ST_IDLE;
            axis_reg  <= gpt_pkg::AXIS_PAN;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.axis    = axis_reg;
        cmd.mul_sel = gpt_pkg::MS_DZ;
        case (state_reg)
            gpt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = gpt_pkg::ST_GATE;
                end
            end
            gpt_pkg::ST_GATE: begin
                axis_next  = gpt_pkg::AXIS_PAN;
                state_next = sts.gate_ok ? gpt_pkg::ST_DZ : gpt_pkg::ST_OUT;
            end
            gpt_pkg::ST_DZ: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = gpt_pkg::MS_DZ;
                state_next  = gpt_pkg::ST_DIV_START;
            end
            gpt_pkg::ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = gpt_pkg::ST_DIV_WAIT;
            end
            gpt_pkg::ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    state_next = gpt_pkg::ST_RATE;
                end
            end
            gpt_pkg::ST_RATE: begin
                cmd.rate_en = 1'b1;
                state_next  = gpt_pkg::ST_MUL_I;
            end
            gpt_pkg::ST_MUL_I: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = gpt_pkg::MS_I;
                state_next  = gpt_pkg::ST_MUL_P;
            end
            gpt_pkg::ST_MUL_P: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = gpt_pkg::MS_P;
                cmd.acc_en  = 1'b1;
                state_next  = gpt_pkg::ST_MUL_D;
            end
            gpt_pkg::ST_MUL_D: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = gpt_pkg::MS_D;
                cmd.cmd_init = 1'b1;
                state_next   = gpt_pkg::ST_MUL_K;
            end
            gpt_pkg::ST_MUL_K: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = gpt_pkg::MS_K;
                cmd.cmd_add = 1'b1;
                state_next  = gpt_pkg::ST_FIN;
            end
            gpt_pkg::ST_FIN: begin
                cmd.fin_en = 1'b1;
                state_next = gpt_pkg::ST_CHAN;
            end
            gpt_pkg::ST_CHAN: begin
                cmd.chan_en = 1'b1;
                if (axis_reg == gpt_pkg::AXIS_PAN) begin
                    axis_next  = gpt_pkg::AXIS_TILT;
                    state_next = gpt_pkg::ST_DZ;
                end else begin
                    state_next = gpt_pkg::ST_OUT;
                end
            end
            gpt_pkg::ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = gpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/gimbal_pan_tilt_pid.sv =====
// Top level of the gimbal pan/tilt PID tracker.
// Depends on gpt_pkg, gpt_ctrl, gpt_datapath (which holds gpt_div).
//
// Usage:
//   s_* channel: one tracked-target transaction per frame (column, row,
//   confidence), valid/ready. m_* channel: one transaction per input with
//   both servo channel values and the control_applied flag.
//   cfg_*: write-only register port, one register per cycle on cfg_wr_en;
//   write only while no transaction is in flight.
// Sequencing:
//   A frame that passes the gate runs through the pan axis, then the tilt
//   axis, then the output load; one that fails goes straight from the gate
//   check to the output load. Each axis runs in turn through one shared
//   32x17 multiplier and a divider that resolves two quotient bits per
//   cycle. s_ready is high only while the controller is idle, which it
//   becomes on the same clock edge that registers the result.
// Reset and stalls:
//   Reset restores register defaults, clears integrals and last rates and
//   sets both channels to 1023. A result waiting on m_ready does not stop
//   the next frame being accepted; that frame's result waits until the
//   output register frees up.
`timescale 1ns / 1ps

module gimbal_pan_tilt_pid (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gpt_pkg::COORD_W-1:0]     s_target_col,
    input  logic [gpt_pkg::COORD_W-1:0]     s_target_row,
    input  logic [gpt_pkg::CONF_W-1:0]      s_track_confidence,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gpt_pkg::CH_W-1:0]        m_pan_channel,
    output logic [gpt_pkg::CH_W-1:0]        m_tilt_channel,
    output logic                            m_control_applied,
    input  logic                            cfg_wr_en,
    input  logic [gpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gpt_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    gpt_pkg::cmd_t cmd;
    gpt_pkg::sts_t sts;

    gpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gpt_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_target_col       (s_target_col),
        .s_target_row       (s_target_row),
        .s_track_confidence (s_track_confidence),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_pan_channel      (m_pan_channel),
        .m_tilt_channel     (m_tilt_channel),
        .m_control_applied  (m_control_applied)
    );

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register loaded while holding a result");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while one is in flight");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> sts.div_done)
        else $error("divider restarted while busy");

    a_chan_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.chan_en || cmd.fin_en) |-> sts.gate_ok)
        else $error("axis state updated for a gated-off transaction");

endmodule
